// ===== rtl/uart_baud_divisor_search_macros.svh =====
// Assertion macros for the baud divisor search block.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef UART_BAUD_DIVISOR_SEARCH_MACROS_SVH
`define UART_BAUD_DIVISOR_SEARCH_MACROS_SVH

// Check a property in the same cycle as its trigger.
`define UBDS_ASSERT_NOW(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (prop)) \
        else $error(msg);

// Check a property in the cycle after its trigger.
`define UBDS_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/ubds_pkg.sv =====
// Package for the baud divisor search: widths, limits, microcode types and program.
// No dependencies; used by every module of the block.
package ubds_pkg;

    // Field and datapath widths
    localparam int BAUD_W    = 24;
    localparam int CLK_W     = 32;
    localparam int PCT_W     = 7;
    localparam int OSR_W     = 5;
    localparam int DIV_W     = 13;
    localparam int MUL_B_W   = 7;
    localparam int PROD_W    = BAUD_W + MUL_B_W;
    localparam int DVD_W     = CLK_W + 1;
    localparam int DVS_W     = PROD_W;
    localparam int DCNT_W    = $clog2(DVD_W + 1);
    localparam int SCALED_W  = DVD_W + PCT_W;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 5;

    // Search limits and reset values
    localparam logic [DIV_W-1:0] DIV_MAX         = 13'd8191;
    localparam logic [OSR_W-1:0] OSR_MIN         = 5'd3;
    localparam logic [OSR_W-1:0] OSR_MAX         = 5'd31;
    localparam logic [OSR_W-1:0] BOTH_EDGE_LIMIT = 5'd8;
    localparam logic [DVS_W-1:0] PERCENT_SCALE   = 31'd100;
    localparam logic [CLK_W-1:0] CLOCK_RESET     = 32'd24000000;
    localparam logic [PCT_W-1:0] PERCENT_RESET   = 7'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERR_PCT = 2'd1;

    // Program steps
    typedef enum logic [STEP_W-1:0] {
        S_INIT      = 5'd0,
        S_DEN_MUL   = 5'd1,
        S_RND_DIV   = 5'd2,
        S_RND_WAIT  = 5'd3,
        S_CHECK     = 5'd4,
        S_BAUD_MUL  = 5'd5,
        S_BAUD_DIV  = 5'd6,
        S_BAUD_WAIT = 5'd7,
        S_EVAL      = 5'd8,
        S_NEXT      = 5'd9,
        S_STEP_OSR  = 5'd10,
        S_FIN_MUL   = 5'd11,
        S_FIN_DIV   = 5'd12,
        S_FIN_WAIT  = 5'd13,
        S_ERR       = 5'd14,
        S_DONE      = 5'd15
    } t_step;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_TARGET_ZERO,
        COND_SKIP,
        COND_EXACT,
        COND_LAST,
        COND_DIV_BUSY
    } t_cond;

    typedef enum logic [1:0] {
        MS_TGT_OSR,
        MS_DIV_OSR,
        MS_BEST,
        MS_TGT_PCT
    } t_mul_sel;

    typedef enum logic [1:0] {
        DS_ROUND,
        DS_BAUD
    } t_div_sel;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INIT,
        ACT_LOAD_DIV,
        ACT_EVAL,
        ACT_INC_OSR,
        ACT_SAVE_ERR,
        ACT_DONE
    } t_action;

    // One control word of the program
    typedef struct packed {
        t_step    jump_to;
        t_cond    cond;
        t_mul_sel mul_sel;
        logic     mul_en;
        logic     div_start;
        t_div_sel div_sel;
        t_action  action;
    } t_ctl;

    // Datapath flags tested by conditional jumps
    typedef struct packed {
        logic target_zero;
        logic skip;
        logic exact;
        logic last;
        logic div_busy;
    } t_seq_flags;

    localparam t_ctl CTL_IDLE = '{
        jump_to:   S_INIT,
        cond:      COND_NEVER,
        mul_sel:   MS_TGT_OSR,
        mul_en:    1'b0,
        div_start: 1'b0,
        div_sel:   DS_ROUND,
        action:    ACT_NONE
    };

    // Program ROM
    function automatic t_ctl ubds_rom(input t_step step);
        t_ctl w;
        w = CTL_IDLE;
        unique case (step)
            S_INIT: begin
                w.action  = ACT_INIT;
                w.cond    = COND_TARGET_ZERO;
                w.jump_to = S_FIN_MUL;
            end
            S_DEN_MUL: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MS_TGT_OSR;
            end
            S_RND_DIV: begin
                w.div_start = 1'b1;
                w.div_sel   = DS_ROUND;
            end
            S_RND_WAIT: begin
                w.cond    = COND_DIV_BUSY;
                w.jump_to = S_RND_WAIT;
            end
            S_CHECK: begin
                w.action  = ACT_LOAD_DIV;
                w.cond    = COND_SKIP;
                w.jump_to = S_NEXT;
            end
            S_BAUD_MUL: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MS_DIV_OSR;
            end
            S_BAUD_DIV: begin
                w.div_start = 1'b1;
                w.div_sel   = DS_BAUD;
            end
            S_BAUD_WAIT: begin
                w.cond    = COND_DIV_BUSY;
                w.jump_to = S_BAUD_WAIT;
            end
            S_EVAL: begin
                w.action  = ACT_EVAL;
                w.cond    = COND_EXACT;
                w.jump_to = S_FIN_MUL;
            end
            S_NEXT: begin
                w.cond    = COND_LAST;
                w.jump_to = S_FIN_MUL;
            end
            S_STEP_OSR: begin
                w.action  = ACT_INC_OSR;
                w.cond    = COND_ALWAYS;
                w.jump_to = S_DEN_MUL;
            end
            S_FIN_MUL: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MS_BEST;
            end
            S_FIN_DIV: begin
                w.div_start = 1'b1;
                w.div_sel   = DS_BAUD;
            end
            S_FIN_WAIT: begin
                w.cond    = COND_DIV_BUSY;
                w.jump_to = S_FIN_WAIT;
            end
            S_ERR: begin
                w.action  = ACT_SAVE_ERR;
                w.mul_en  = 1'b1;
                w.mul_sel = MS_TGT_PCT;
            end
            S_DONE: begin
                w.action  = ACT_DONE;
                w.cond    = COND_ALWAYS;
                w.jump_to = S_INIT;
            end
            default: begin
                w = CTL_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/ubds_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by every division of the search.
// Depends on ubds_pkg for operand widths.
module ubds_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ubds_pkg::DVD_W-1:0] i_dividend,
    input  logic [ubds_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [ubds_pkg::DVD_W-1:0] o_quotient
);

    logic [ubds_pkg::DCNT_W-1:0] r_cnt;
    logic [ubds_pkg::DVS_W-1:0]  r_rem;
    logic [ubds_pkg::DVS_W-1:0]  r_dvs;
    logic [ubds_pkg::DVD_W-1:0]  r_q;

    logic [ubds_pkg::DVS_W:0]    trial;
    logic [ubds_pkg::DVS_W:0]    diff;
    logic                        fits;
    logic [ubds_pkg::DVS_W-1:0]  n_rem;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_q[ubds_pkg::DVD_W-1]};
        fits  = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
        n_rem = fits ? diff[ubds_pkg::DVS_W-1:0] : trial[ubds_pkg::DVS_W-1:0];
    end

    // Count the bit steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= ubds_pkg::DCNT_W'(ubds_pkg::DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - ubds_pkg::DCNT_W'(1);
        end
    end

    // Load operands, then move dividend bits out and quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_q   <= {r_q[ubds_pkg::DVD_W-2:0], fits};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_q;

endmodule

// ===== rtl/ubds_sequencer.sv =====
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on ubds_pkg for the control word, flags and program.
module ubds_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_run,
    input  ubds_pkg::t_seq_flags i_flags,
    output ubds_pkg::t_ctl       o_ctl
);

    ubds_pkg::t_step r_pc;
    ubds_pkg::t_step n_pc;
    ubds_pkg::t_ctl  word;
    logic            take;

    // Hold the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ubds_pkg::S_INIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Fetch the word, test its condition, pick the next step
    always_comb begin
        word = ubds_pkg::ubds_rom(r_pc);
        unique case (word.cond)
            ubds_pkg::COND_NEVER:       take = 1'b0;
            ubds_pkg::COND_ALWAYS:      take = 1'b1;
            ubds_pkg::COND_TARGET_ZERO: take = i_flags.target_zero;
            ubds_pkg::COND_SKIP:        take = i_flags.skip;
            ubds_pkg::COND_EXACT:       take = i_flags.exact;
            ubds_pkg::COND_LAST:        take = i_flags.last;
            ubds_pkg::COND_DIV_BUSY:    take = i_flags.div_busy;
            default:                    take = 1'b0;
        endcase
        if (!i_run) begin
            n_pc  = r_pc;
            o_ctl = ubds_pkg::CTL_IDLE;
        end else begin
            n_pc  = take ? word.jump_to
                         : ubds_pkg::t_step'(ubds_pkg::STEP_W'(r_pc) + 5'd1);
            o_ctl = word;
        end
    end

endmodule

// ===== rtl/uart_baud_divisor_search.sv =====
// Top level of the UART baud divisor search: ports, configuration and datapath.
// Depends on ubds_pkg, ubds_sequencer, ubds_divider and the assertion macros header.
//
// Channel   Direction  Handshake                     Payload
// request   in         i_start, o_busy               i_target_baud
// result    out        o_done (one-cycle strobe)     o_oversample, o_divisor, o_status,
//                                                    o_both_edge
// config    in         i_cfg_valid, o_cfg_ready      i_cfg_index, i_cfg_data
//
// One request at a time: each oversampling candidate takes two divisions, a skipped one
// takes one, and one more division closes the search.
// Every division runs on the shared one-bit-per-cycle divider.
// o_busy rises at the accepting edge and falls at the edge that raises o_done.
// Synchronous reset restores clock_hz to 24000000 and max_error_percent to 3.
// The result strobe lasts one cycle; the receiver cannot stall it. Config is always ready.
`include "uart_baud_divisor_search_macros.svh"

module uart_baud_divisor_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [ubds_pkg::BAUD_W-1:0]       i_target_baud,
    output logic                              o_done,
    output logic [ubds_pkg::OSR_W-1:0]        o_oversample,
    output logic [ubds_pkg::DIV_W-1:0]        o_divisor,
    output logic                              o_status,
    output logic                              o_both_edge,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ubds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ubds_pkg::CLK_W-1:0]        i_cfg_data
);

    // Control and configuration
    logic                           r_busy;
    logic [ubds_pkg::CLK_W-1:0]     r_clock_hz;
    logic [ubds_pkg::PCT_W-1:0]     r_percent;

    // Search state
    logic [ubds_pkg::BAUD_W-1:0]    r_target;
    logic [ubds_pkg::OSR_W-1:0]     r_osr;
    logic [ubds_pkg::DIV_W-1:0]     r_div;
    logic [ubds_pkg::DIV_W-1:0]     r_best_div;
    logic [ubds_pkg::OSR_W-1:0]     r_best_ovs;
    logic [ubds_pkg::BAUD_W-1:0]    r_best_err;
    logic [ubds_pkg::PROD_W-1:0]    r_prod;
    logic [ubds_pkg::DVD_W-1:0]     r_err;

    // Result registers
    logic                           r_out_valid;
    logic [ubds_pkg::OSR_W-1:0]     r_out_osr;
    logic [ubds_pkg::DIV_W-1:0]     r_out_div;
    logic                           r_out_status;
    logic                           r_out_both;

    ubds_pkg::t_ctl                 ctl;
    ubds_pkg::t_seq_flags           flags;
    logic                           accept;
    logic [ubds_pkg::BAUD_W-1:0]    mul_a;
    logic [ubds_pkg::MUL_B_W-1:0]   mul_b;
    logic [ubds_pkg::PROD_W-1:0]    mul_p;
    logic [ubds_pkg::DVD_W-1:0]     dvd;
    logic [ubds_pkg::DVS_W-1:0]     dvs;
    logic                           div_busy;
    logic [ubds_pkg::DVD_W-1:0]     quot;
    logic [ubds_pkg::DVD_W-1:0]     target_x;
    logic [ubds_pkg::DVD_W-1:0]     abs_err;
    logic [ubds_pkg::SCALED_W-1:0]  err_wide;
    logic [ubds_pkg::SCALED_W-1:0]  err_scaled;

    assign accept      = i_start && !r_busy;
    assign o_cfg_ready = 1'b1;

    // Pick multiplier operands
    always_comb begin
        case (ctl.mul_sel)
            ubds_pkg::MS_TGT_OSR: begin
                mul_a = r_target;
                mul_b = ubds_pkg::MUL_B_W'(r_osr) + 7'd1;
            end
            ubds_pkg::MS_DIV_OSR: begin
                mul_a = ubds_pkg::BAUD_W'(r_div);
                mul_b = ubds_pkg::MUL_B_W'(r_osr) + 7'd1;
            end
            ubds_pkg::MS_BEST: begin
                mul_a = ubds_pkg::BAUD_W'(r_best_div);
                mul_b = ubds_pkg::MUL_B_W'(r_best_ovs) + 7'd1;
            end
            default: begin
                mul_a = r_target;
                mul_b = r_percent;
            end
        endcase
        mul_p = ubds_pkg::PROD_W'(mul_a) * ubds_pkg::PROD_W'(mul_b);
    end

    // Pick divider operands
    always_comb begin
        case (ctl.div_sel)
            ubds_pkg::DS_ROUND: begin
                dvd = {1'b0, r_clock_hz}
                    + ubds_pkg::DVD_W'(r_prod[ubds_pkg::PROD_W-1:1]);
                dvs = r_prod;
            end
            default: begin
                dvd = {1'b0, r_clock_hz};
                dvs = r_prod;
            end
        endcase
    end

    // Absolute distance of the last quotient from the target
    always_comb begin
        target_x = ubds_pkg::DVD_W'(r_target);
        abs_err  = (quot > target_x) ? (quot - target_x) : (target_x - quot);
    end

    // Scale the final error by 100 (64 + 32 + 4); it is above floor(target * pct / 100)
    // exactly when this exceeds target * pct
    always_comb begin
        err_wide   = ubds_pkg::SCALED_W'(r_err);
        err_scaled = (err_wide << 6) + (err_wide << 5) + (err_wide << 2);
    end

    // Flags for conditional jumps
    always_comb begin
        flags.target_zero = (r_target == '0);
        flags.skip        = (quot == '0) || (quot > ubds_pkg::DVD_W'(ubds_pkg::DIV_MAX));
        flags.exact       = (quot == target_x);
        flags.last        = (r_osr == ubds_pkg::OSR_MAX);
        flags.div_busy    = div_busy;
    end

    ubds_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (r_busy),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    ubds_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= ubds_pkg::CLOCK_RESET;
            r_percent  <= ubds_pkg::PERCENT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ubds_pkg::CFG_CLOCK_HZ) begin
                r_clock_hz <= i_cfg_data;
            end else if (i_cfg_index == ubds_pkg::CFG_MAX_ERR_PCT) begin
                r_percent <= i_cfg_data[ubds_pkg::PCT_W-1:0];
            end
        end
    end

    // Track busy and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (ctl.action == ubds_pkg::ACT_DONE);
            if (accept) begin
                r_busy <= 1'b1;
            end else if (ctl.action == ubds_pkg::ACT_DONE) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Run the datapath actions of each step
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_target   <= i_target_baud;
            r_best_div <= ubds_pkg::DIV_MAX;
            r_best_ovs <= ubds_pkg::OSR_MAX;
            r_best_err <= i_target_baud;
        end
        if (ctl.mul_en) begin
            r_prod <= mul_p;
        end
        case (ctl.action)
            ubds_pkg::ACT_INIT: begin
                r_osr <= ubds_pkg::OSR_MIN;
            end
            ubds_pkg::ACT_LOAD_DIV: begin
                r_div <= quot[ubds_pkg::DIV_W-1:0];
            end
            ubds_pkg::ACT_EVAL: begin
                if (abs_err < ubds_pkg::DVD_W'(r_best_err)) begin
                    r_best_err <= abs_err[ubds_pkg::BAUD_W-1:0];
                    r_best_div <= r_div;
                    r_best_ovs <= r_osr;
                end
            end
            ubds_pkg::ACT_INC_OSR: begin
                r_osr <= r_osr + ubds_pkg::OSR_W'(1);
            end
            ubds_pkg::ACT_SAVE_ERR: begin
                r_err <= abs_err;
            end
            ubds_pkg::ACT_DONE: begin
                r_out_osr    <= r_best_ovs;
                r_out_div    <= r_best_div;
                r_out_status <= (err_scaled > ubds_pkg::SCALED_W'(r_prod));
                r_out_both   <= (r_best_ovs <= ubds_pkg::BOTH_EDGE_LIMIT);
            end
            default: begin
            end
        endcase
    end

    assign o_busy       = r_busy;
    assign o_done       = r_out_valid;
    assign o_oversample = r_out_osr;
    assign o_divisor    = r_out_div;
    assign o_status     = r_out_status;
    assign o_both_edge  = r_out_both;

    // The last step ends the transaction and raises the strobe
    `UBDS_ASSERT_NEXT(a_done_ends_busy, ctl.action == ubds_pkg::ACT_DONE, r_out_valid && !r_busy, "done step did not end the transaction")
    // The result strobe falls straight after it rises
    `UBDS_ASSERT_NEXT(a_strobe_single, r_out_valid, !r_out_valid, "result strobe held two cycles")
    // The divider is never restarted while it works
    `UBDS_ASSERT_NOW(a_div_no_restart, ctl.div_start, !div_busy, "divider started while busy")
    // The best error never exceeds the target
    `UBDS_ASSERT_NOW(a_best_err_bound, r_busy, r_best_err <= r_target, "best error above target")
    // A delivered setting is within range
    `UBDS_ASSERT_NOW(a_out_range, r_out_valid, (r_out_div != '0) && (r_out_osr >= ubds_pkg::OSR_MIN), "result setting out of range")

endmodule
